### hw/rtl/cdcr_pkg.sv
package cdcr_pkg;

  localparam int DIGITS        = 8;
  localparam int BCD_W         = 4 * DIGITS;
  localparam int CEIL_W        = 27;
  localparam int BIN_W         = 28;
  localparam int DABBLE_STEPS  = 7;
  localparam int DABBLE_STAGES = BIN_W / DABBLE_STEPS;

  localparam logic [CEIL_W-1:0] EIGHT_DIGIT_MAX = 27'd99999999;

  localparam int FIELD_LEFT = 16;
  localparam int CELL_PITCH = 12;
  localparam int LABEL_LEFT = 58;
  localparam int LABEL_SPAN = 11;
  localparam int ICON_LEFT  = 106;
  localparam int ICON_SPAN  = 20;
  localparam int BAND_TOP   = 8;
  localparam int BAND_H     = 6;

  localparam logic [2:0] LABEL_NONE = 3'd0;
  localparam logic [2:0] BARS_HIDE  = 3'd7;

  typedef struct packed {
    logic [BCD_W-1:0] bcd;
    logic [BIN_W-1:0] bin;
  } dabble_t;

  typedef struct packed {
    logic       hide;
    logic       dig_area;
    logic [2:0] slot;
    logic [3:0] xo;
    logic [2:0] page;
    logic [7:0] side;
  } ctl_t;

  function automatic logic [6:0] font_column(input logic [3:0] digit, input logic [2:0] col);
    logic [34:0] glyph;
    unique case (digit)
      4'd0:    glyph = {7'h3e, 7'h45, 7'h49, 7'h51, 7'h3e};
      4'd1:    glyph = {7'h00, 7'h40, 7'h7f, 7'h42, 7'h00};
      4'd2:    glyph = {7'h46, 7'h49, 7'h51, 7'h61, 7'h42};
      4'd3:    glyph = {7'h31, 7'h4b, 7'h45, 7'h41, 7'h21};
      4'd4:    glyph = {7'h10, 7'h7f, 7'h12, 7'h14, 7'h18};
      4'd5:    glyph = {7'h39, 7'h45, 7'h45, 7'h45, 7'h27};
      4'd6:    glyph = {7'h30, 7'h49, 7'h49, 7'h4a, 7'h3c};
      4'd7:    glyph = {7'h03, 7'h05, 7'h09, 7'h71, 7'h01};
      4'd8:    glyph = {7'h36, 7'h49, 7'h49, 7'h49, 7'h36};
      4'd9:    glyph = {7'h1e, 7'h29, 7'h49, 7'h49, 7'h06};
      default: glyph = '0;
    endcase
    if (col > 3'd4) begin
      return '0;
    end
    return glyph[col*7 +: 7];
  endfunction

  function automatic logic [4:0] letter_column(input logic [2:0] label, input logic [3:0] idx);
    logic [54:0] strip;
    unique case (label)
      3'd1:    strip = {5'h1a, 5'h05, 5'h1f, 5'h00, 5'h1a, 5'h05, 5'h1f, 5'h00,
                        5'h11, 5'h15, 5'h1f};
      3'd2:    strip = {5'h1b, 5'h04, 5'h1b, 5'h00, 5'h1e, 5'h05, 5'h1e, 5'h00,
                        5'h1f, 5'h02, 5'h1f};
      3'd3:    strip = {5'h01, 5'h1f, 5'h01, 5'h00, 5'h1d, 5'h15, 5'h17, 5'h00,
                        5'h1a, 5'h05, 5'h1f};
      3'd4:    strip = {5'h00, 5'h00, 5'h00, 5'h00, 5'h0e, 5'h11, 5'h0e, 5'h00,
                        5'h10, 5'h10, 5'h1f};
      3'd5:    strip = {5'h1d, 5'h11, 5'h0e, 5'h00, 5'h1f, 5'h04, 5'h1f, 5'h00,
                        5'h11, 5'h11, 5'h0e};
      3'd6:    strip = {5'h01, 5'h1f, 5'h01, 5'h00, 5'h1e, 5'h05, 5'h1e, 5'h00,
                        5'h0a, 5'h15, 5'h1f};
      3'd7:    strip = {5'h01, 5'h1f, 5'h01, 5'h00, 5'h02, 5'h05, 5'h1f, 5'h00,
                        5'h0e, 5'h11, 5'h0e};
      default: strip = '0;
    endcase
    if (idx >= 4'(LABEL_SPAN)) begin
      return '0;
    end
    return strip[idx*5 +: 5];
  endfunction

  // One column of the battery outline for page 0.
  function automatic logic [7:0] battery_column(input logic [2:0] bars, input logic [7:0] column);
    logic [4:0] x;
    logic [3:0] xm;
    x  = 5'(column - 8'(ICON_LEFT));
    xm = 4'(x - 5'd2);
    priority if (bars == BARS_HIDE || column < 8'(ICON_LEFT) ||
                 column >= 8'(ICON_LEFT + ICON_SPAN)) begin
      return 8'h00;
    end else if (x == 5'd0 || x == 5'd17) begin
      return 8'h7e;
    end else if (x == 5'd18 || x == 5'd19) begin
      return 8'h18;
    end else if (x < 5'd2) begin
      return 8'h42;
    end else if (xm[1:0] != 2'd3 && {1'b0, xm[3:2]} < bars) begin
      return 8'h7e;
    end else begin
      return 8'h42;
    end
  endfunction

  // Spread the seven font rows over the eight pixel rows of one page.
  function automatic logic [7:0] band_expand(input logic [6:0] dots, input logic [2:0] page);
    logic [7:0] bits;
    logic [5:0] row;
    bits = '0;
    for (int b = 0; b < 8; b++) begin
      row = {page, 3'(b)};
      for (int r = 0; r < 7; r++) begin
        if (row >= 6'(BAND_TOP + BAND_H * r) && row < 6'(BAND_TOP + BAND_H * (r + 1))) begin
          bits[b] = bits[b] | dots[r];
        end
      end
    end
    return bits;
  endfunction

endpackage

### hw/rtl/cdcr_dabble.sv
module cdcr_dabble (
  input  cdcr_pkg::dabble_t d_in,
  output cdcr_pkg::dabble_t d_out
);
  import cdcr_pkg::*;

  // A slice of shift-and-add-3 binary to BCD conversion.
  always_comb begin
    dabble_t          work;
    logic [BCD_W-1:0] adj;
    logic [3:0]       nib;
    work = d_in;
    adj  = '0;
    nib  = '0;
    for (int s = 0; s < DABBLE_STEPS; s++) begin
      for (int n = 0; n < DIGITS; n++) begin
        nib = work.bcd[n*4 +: 4];
        adj[n*4 +: 4] = (nib >= 4'd5) ? 4'(nib + 4'd3) : nib;
      end
      work.bcd = {adj[BCD_W-2:0], work.bin[BIN_W-1]};
      work.bin = {work.bin[BIN_W-2:0], 1'b0};
    end
    d_out = work;
  end

endmodule

### hw/rtl/counter_display_column_renderer_top.sv
// Channel   Direction  Handshake           Word
// cfg       in         cfg_write           cfg_data: count ceiling, 27 bits
// in        in         in_valid/in_stall   count, label, bars, hide, page, column
// out       out        out_valid/out_stall pixel_byte
//
// One word per clock sustained while out_stall is low; a word passes one
// decode/clamp stage, four binary to BCD stages (seven shift-add-3 steps
// each), one glyph lookup stage and the output register before out_valid.
// Each stage holds its word while the stage after it is full and stalled,
// so bubbles are squeezed out and in_stall rises only when all seven are full.
// rst (synchronous) clears the stage valid bits and loads the ceiling with
// 99999999.
module counter_display_column_renderer_top (
  input  logic                        clk,
  input  logic                        rst,
  input  logic                        cfg_write,
  input  logic [cdcr_pkg::CEIL_W-1:0] cfg_data,
  input  logic                        in_valid,
  output logic                        in_stall,
  input  logic [31:0]                 count_value,
  input  logic [2:0]                  label_code,
  input  logic [2:0]                  battery_bars,
  input  logic                        blank_digits,
  input  logic [3:0]                  page_index,
  input  logic [7:0]                  column_index,
  output logic                        out_valid,
  input  logic                        out_stall,
  output logic [7:0]                  pixel_byte
);
  import cdcr_pkg::*;

  localparam int STAGES = DABBLE_STAGES + 3;
  localparam int GLYPH  = DABBLE_STAGES + 1;
  localparam int LAST   = DABBLE_STAGES + 2;

  // Ceiling is stored already limited to eight digits.
  logic [CEIL_W-1:0] ceiling;

  logic [STAGES-1:0] vld;
  logic [STAGES:0]   rdy;

  dabble_t dab_q [DABBLE_STAGES+1];
  dabble_t dab_d [DABBLE_STAGES];
  ctl_t    ctl_q [DABBLE_STAGES+1];

  logic [6:0] dots;
  logic [2:0] dots_page;
  logic [7:0] dots_side;

  // Input decode
  logic [CEIL_W-1:0] clamped;
  logic [6:0]        field_x;
  logic [14:0]       cell_prod;
  logic [2:0]        cell0;
  logic [3:0]        xo0;
  logic              dig_area0;
  logic [7:0]        label_byte;
  logic [7:0]        batt_byte;
  ctl_t              ctl0;

  // Glyph stage
  logic [BCD_W-1:0]  bcd;
  logic [2:0]        nib_idx;
  logic [3:0]        digit;
  logic [DIGITS-1:0] lead;
  logic              acc;
  logic              shown;
  logic [6:0]        dots_next;

  logic              bcd_ok;

  always_ff @(posedge clk) begin
    if (rst) begin
      ceiling <= EIGHT_DIGIT_MAX;
    end else if (cfg_write) begin
      ceiling <= (cfg_data > EIGHT_DIGIT_MAX) ? EIGHT_DIGIT_MAX : cfg_data;
    end
  end

  // A stage may load when it is empty or its word moves on this cycle.
  always_comb begin
    rdy[STAGES] = !out_stall;
    for (int k = STAGES - 1; k >= 0; k--) begin
      rdy[k] = !vld[k] || rdy[k+1];
    end
  end

  assign in_stall  = !rdy[0];
  assign out_valid = vld[LAST];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else begin
      if (rdy[0]) begin
        vld[0] <= in_valid;
      end
      for (int k = 1; k < STAGES; k++) begin
        if (rdy[k]) begin
          vld[k] <= vld[k-1];
        end
      end
    end
  end

  // Stage 0: clamp the count, locate the column inside a digit cell, and
  // draw the label and battery, which need nothing from the count.
  always_comb begin
    clamped   = (count_value > {5'b0, ceiling}) ? ceiling : count_value[CEIL_W-1:0];
    field_x   = 7'(column_index - 8'(FIELD_LEFT));
    // x / 12 by reciprocal: exact for x below 96
    cell_prod = 15'(field_x) * 15'd171;
    cell0     = cell_prod[13:11];
    xo0       = 4'(field_x - 7'(cell0) * 7'(CELL_PITCH));
    dig_area0 = (page_index >= 4'd1) && (page_index <= 4'd6) &&
                (column_index >= 8'(FIELD_LEFT)) &&
                (column_index < 8'(FIELD_LEFT + DIGITS * CELL_PITCH));
    label_byte = 8'h00;
    if (label_code != LABEL_NONE && page_index == 4'd7 &&
        column_index >= 8'(LABEL_LEFT) && column_index < 8'(LABEL_LEFT + LABEL_SPAN)) begin
      label_byte = {1'b0, letter_column(label_code, 4'(column_index - 8'(LABEL_LEFT))), 2'b00};
    end
    batt_byte = (page_index == 4'd0) ? battery_column(battery_bars, column_index) : 8'h00;
    ctl0.hide     = blank_digits;
    ctl0.dig_area = dig_area0;
    ctl0.slot     = cell0;
    ctl0.xo       = xo0;
    ctl0.page     = page_index[2:0];
    ctl0.side     = label_byte | batt_byte;
  end

  always_ff @(posedge clk) begin
    if (rdy[0]) begin
      dab_q[0] <= '{bcd: '0, bin: {{(BIN_W - CEIL_W){1'b0}}, clamped}};
      ctl_q[0] <= ctl0;
    end
  end

  // Stages 1..4: binary to BCD, one slice per stage.
  for (genvar g = 0; g < DABBLE_STAGES; g++) begin : g_dabble
    cdcr_dabble u_dabble (
      .d_in  (dab_q[g]),
      .d_out (dab_d[g])
    );

    always_ff @(posedge clk) begin
      if (rdy[g+1]) begin
        dab_q[g+1] <= dab_d[g];
        ctl_q[g+1] <= ctl_q[g];
      end
    end
  end

  // Glyph stage: pick the cell's digit, blank leading zeros, fetch the font
  // column. Cell 0 is the most significant digit.
  always_comb begin
    bcd     = dab_q[DABBLE_STAGES].bcd;
    nib_idx = 3'(DIGITS - 1) - ctl_q[DABBLE_STAGES].slot;
    digit   = bcd[nib_idx*4 +: 4];
    acc     = 1'b0;
    for (int c = 0; c < DIGITS; c++) begin
      acc     = acc | (bcd[(DIGITS-1-c)*4 +: 4] != 4'd0);
      lead[c] = acc;
    end
    shown = !ctl_q[DABBLE_STAGES].hide &&
            (ctl_q[DABBLE_STAGES].slot == 3'(DIGITS - 1) || lead[ctl_q[DABBLE_STAGES].slot]);
    dots_next = 7'h00;
    if (ctl_q[DABBLE_STAGES].dig_area && ctl_q[DABBLE_STAGES].xo < 4'd10 && shown) begin
      dots_next = font_column(digit, ctl_q[DABBLE_STAGES].xo[3:1]);
    end
  end

  always_ff @(posedge clk) begin
    if (rdy[GLYPH]) begin
      dots      <= dots_next;
      dots_page <= ctl_q[DABBLE_STAGES].page;
      dots_side <= ctl_q[DABBLE_STAGES].side;
    end
  end

  // Output register: stretch font rows over the page and merge the rest.
  always_ff @(posedge clk) begin
    if (rdy[LAST]) begin
      pixel_byte <= band_expand(dots, dots_page) | dots_side;
    end
  end

  always_comb begin
    bcd_ok = 1'b1;
    for (int n = 0; n < DIGITS; n++) begin
      bcd_ok = bcd_ok && (bcd[n*4 +: 4] <= 4'd9);
    end
  end

  // An accepted word always lands in the first stage.
  a_accept_lands: assert property (@(posedge clk) disable iff (rst)
    (in_valid && !in_stall) |=> vld[0])
    else $error("accepted word did not reach the first stage");

  // The clamped count never exceeds eight digits.
  a_clamp_range: assert property (@(posedge clk) disable iff (rst)
    vld[0] |-> (dab_q[0].bin <= BIN_W'(EIGHT_DIGIT_MAX)))
    else $error("clamped count above eight digits");

  // After the last conversion slice every digit is decimal.
  a_bcd_digits: assert property (@(posedge clk) disable iff (rst)
    vld[DABBLE_STAGES] |-> bcd_ok)
    else $error("converted count holds a non-decimal digit");

endmodule

### tb/counter_display_column_renderer_top_tb.sv
module counter_display_column_renderer_top_tb;

  // Panel geometry, kept apart from the package so that a wrong constant
  // there shows up as a mismatch here.
  localparam int DIGIT_X0    = 16;
  localparam int DIGIT_PITCH = 12;
  localparam int TAG_X0      = 58;
  localparam int TAG_WIDTH   = 11;
  localparam int BATT_X0     = 106;
  localparam int BATT_WIDTH  = 20;
  localparam logic [26:0] SHOWN_MAX = 27'd99999999;
  localparam logic [2:0]  BARS_OFF  = 3'd7;

  localparam int CYCLE_LIMIT = 1000000;
  localparam int HOLD_CYCLES = 80;
  localparam int PHASE_WORDS = 275;

  // Label codes as the input word carries them.
  typedef enum logic [2:0] {
    TAG_NONE, TAG_ERR, TAG_MAX, TAG_RST, TAG_LO, TAG_CHG, TAG_BAT, TAG_OPT
  } tag_e;

  // 5x7 digit font: five columns per digit, bit 0 is the top font row.
  localparam logic [0:9][0:4][7:0] GLYPH = {
    8'h3e, 8'h51, 8'h49, 8'h45, 8'h3e,
    8'h00, 8'h42, 8'h7f, 8'h40, 8'h00,
    8'h42, 8'h61, 8'h51, 8'h49, 8'h46,
    8'h21, 8'h41, 8'h45, 8'h4b, 8'h31,
    8'h18, 8'h14, 8'h12, 8'h7f, 8'h10,
    8'h27, 8'h45, 8'h45, 8'h45, 8'h39,
    8'h3c, 8'h4a, 8'h49, 8'h49, 8'h30,
    8'h01, 8'h71, 8'h09, 8'h05, 8'h03,
    8'h36, 8'h49, 8'h49, 8'h49, 8'h36,
    8'h06, 8'h49, 8'h49, 8'h29, 8'h1e
  };

  // Up to three 3x5 letters per label with a blank column between them.
  localparam logic [0:7][0:10][4:0] LETTERS = {
    5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00, 5'h00,
    5'h1f, 5'h15, 5'h11, 5'h00, 5'h1f, 5'h05, 5'h1a, 5'h00, 5'h1f, 5'h05, 5'h1a,
    5'h1f, 5'h02, 5'h1f, 5'h00, 5'h1e, 5'h05, 5'h1e, 5'h00, 5'h1b, 5'h04, 5'h1b,
    5'h1f, 5'h05, 5'h1a, 5'h00, 5'h17, 5'h15, 5'h1d, 5'h00, 5'h01, 5'h1f, 5'h01,
    5'h1f, 5'h10, 5'h10, 5'h00, 5'h0e, 5'h11, 5'h0e, 5'h00, 5'h00, 5'h00, 5'h00,
    5'h0e, 5'h11, 5'h11, 5'h00, 5'h1f, 5'h04, 5'h1f, 5'h00, 5'h0e, 5'h11, 5'h1d,
    5'h1f, 5'h15, 5'h0a, 5'h00, 5'h1e, 5'h05, 5'h1e, 5'h00, 5'h01, 5'h1f, 5'h01,
    5'h0e, 5'h11, 5'h0e, 5'h00, 5'h1f, 5'h05, 5'h02, 5'h00, 5'h01, 5'h1f, 5'h01
  };

  // Ceilings for the first random phases; the later ones draw a random value.
  localparam logic [0:3][26:0] CEIL_STEPS = {27'h7ffffff, 27'd0, SHOWN_MAX, 27'd1000};

  // One request word: which spot of the panel, and what the panel shows.
  typedef struct packed {
    logic [31:0] count;
    logic [2:0]  tag;
    logic [2:0]  bars;
    logic        hide;
    logic [3:0]  page;
    logic [7:0]  column;
  } column_req_t;

  // Renders the expected pixel byte of each accepted request word and
  // holds the bytes in arrival order until the block delivers them.
  class pixel_scoreboard;
    logic [26:0] ceiling;
    logic [7:0]  pixel_queue[$];
    int          errors;

    function new();
      ceiling = SHOWN_MAX;
      errors  = 0;
    endfunction

    function logic [7:0] battery_byte(logic [2:0] bars, int col);
      int x;
      if (bars == BARS_OFF || col < BATT_X0 || col >= BATT_X0 + BATT_WIDTH) return 8'h00;
      x = col - BATT_X0;
      if (x == 0 || x == 17) return 8'h7e;
      if (x == 18 || x == 19) return 8'h18;
      if (x < 2) return 8'h42;
      // Each bar is three filled columns followed by one outline column.
      if (x <= 16 && (x - 2) % 4 < 3 && (x - 2) / 4 < int'(bars)) return 8'h7e;
      return 8'h42;
    endfunction

    function logic [7:0] render(column_req_t q);
      logic [26:0] lim;
      logic [31:0] val;
      logic [3:0]  digit [8];
      logic [7:0]  dots;
      logic [7:0]  pix;
      int          pg, col, x, slot, lo, hi;
      lim = (ceiling > SHOWN_MAX) ? SHOWN_MAX : ceiling;
      val = (q.count > {5'd0, lim}) ? {5'd0, lim} : q.count;
      // Split into digits; blank leading zeros but always keep the last one.
      for (int i = 7; i >= 0; i--) begin
        digit[i] = (!q.hide && (val != 0 || i == 7)) ? 4'(val % 10) : 4'd10;
        val = val / 10;
      end
      pg  = int'(q.page);
      col = int'(q.column);
      pix = 8'h00;
      if (pg < 8 && col < 128) begin
        if (col >= DIGIT_X0 && col < DIGIT_X0 + 8 * DIGIT_PITCH && pg >= 1 && pg <= 6) begin
          x    = col - DIGIT_X0;
          slot = x / DIGIT_PITCH;
          x    = x % DIGIT_PITCH;
          if (x < 10 && digit[slot] < 4'd10) begin
            dots = GLYPH[digit[slot]][x / 2];
            // Font row r covers pixel rows 8+6r..13+6r; clip to this page.
            for (int r = 0; r < 7; r++) begin
              if (dots[r]) begin
                lo = 8 + 6 * r - 8 * pg;
                hi = lo + 6;
                if (lo < 0) lo = 0;
                if (hi > 8) hi = 8;
                if (lo < hi) pix = pix | 8'(((1 << hi) - 1) & ~((1 << lo) - 1));
              end
            end
          end
        end
        if (q.tag != TAG_NONE && pg == 7 && col >= TAG_X0 && col < TAG_X0 + TAG_WIDTH) begin
          pix = {1'b0, LETTERS[q.tag][col - TAG_X0], 2'b00};
        end
        if (pg == 0) pix = pix | battery_byte(q.bars, col);
      end
      return pix;
    endfunction

    function void note_word(column_req_t q);
      pixel_queue.push_back(render(q));
    endfunction

    function void check_word(logic [7:0] got);
      logic [7:0] want;
      if (pixel_queue.size() == 0) begin
        $error("pixel_byte: expected none, actual %02h", got);
        errors++;
      end else begin
        want = pixel_queue.pop_front();
        if (got !== want) begin
          $error("pixel_byte: expected %02h, actual %02h", want, got);
          errors++;
        end
      end
    endfunction

    function int pending();
      return pixel_queue.size();
    endfunction
  endclass

  logic        clk = 1'b0;
  logic        rst;
  logic        cfg_write;
  logic [26:0] cfg_data;
  logic        in_valid;
  logic        in_stall;
  logic [31:0] count_value;
  logic [2:0]  label_code;
  logic [2:0]  battery_bars;
  logic        blank_digits;
  logic [3:0]  page_index;
  logic [7:0]  column_index;
  logic        out_valid;
  logic        out_stall;
  logic [7:0]  pixel_byte;

  pixel_scoreboard pixels = new();

  int cycle_count = 0;
  int hold_asks   = 0;   // bumped by the stimulus, served by the stall process
  bit steady_send = 1'b0;

  counter_display_column_renderer_top dut (
    .clk          (clk),
    .rst          (rst),
    .cfg_write    (cfg_write),
    .cfg_data     (cfg_data),
    .in_valid     (in_valid),
    .in_stall     (in_stall),
    .count_value  (count_value),
    .label_code   (label_code),
    .battery_bars (battery_bars),
    .blank_digits (blank_digits),
    .page_index   (page_index),
    .column_index (column_index),
    .out_valid    (out_valid),
    .out_stall    (out_stall),
    .pixel_byte   (pixel_byte)
  );

  always begin
    #2 clk = 1'b1;
    #2 clk = 1'b0;
  end

  // Abort a hung run.
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("DONE: errors detected");
      $finish;
    end
  end

  // Check every pixel word the block hands over.
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall) pixels.check_word(pixel_byte);
  end

  // Receiver: stall in runs of varying style; serve long hold requests by
  // counting the hold here, independent of what the sender does.
  initial begin
    int span, style, served;
    served = 0;
    out_stall <= 1'b0;
    forever begin
      style = $urandom_range(0, 9);
      span  = $urandom_range(4, 40);
      repeat (span) begin
        @(negedge clk);
        if (hold_asks != served) begin
          out_stall <= 1'b1;
          repeat (HOLD_CYCLES - 1) @(negedge clk);
          served++;
        end else if (style < 4) begin
          out_stall <= 1'b0;
        end else if (style < 8) begin
          out_stall <= ($urandom_range(0, 9) < 3);
        end else if (style == 8) begin
          out_stall <= 1'b1;
        end else begin
          out_stall <= ($urandom_range(0, 9) < 7);
        end
      end
    end
  end

  function automatic int pick_gap();
    int r;
    r = $urandom_range(0, 99);
    if (steady_send || r < 55) return 0;
    if (r < 90) return $urandom_range(1, 3);
    if (r < 98) return $urandom_range(4, 10);
    return $urandom_range(20, 50);
  endfunction

  // Offer one word after an optional gap; hold it until the block takes it.
  task automatic send_word(input column_req_t q);
    int gap;
    gap = pick_gap();
    repeat (gap) begin
      @(negedge clk);
      in_valid <= 1'b0;
    end
    @(negedge clk);
    in_valid     <= 1'b1;
    count_value  <= q.count;
    label_code   <= q.tag;
    battery_bars <= q.bars;
    blank_digits <= q.hide;
    page_index   <= q.page;
    column_index <= q.column;
    do @(posedge clk); while (in_stall);
    pixels.note_word(q);
  endtask

  // Drop valid right after the last accepted word so it is not taken twice.
  task automatic idle_sender();
    @(negedge clk);
    in_valid <= 1'b0;
  endtask

  task automatic drain();
    while (pixels.pending() != 0) @(posedge clk);
  endtask

  // Only called with nothing in flight.
  task automatic write_ceiling(input logic [26:0] value);
    @(negedge clk);
    cfg_write <= 1'b1;
    cfg_data  <= value;
    @(negedge clk);
    cfg_write <= 1'b0;
    pixels.ceiling = value;
  endtask

  function automatic column_req_t mk(logic [31:0] c, tag_e t, logic [2:0] b, logic h,
                                     logic [3:0] p, logic [7:0] col);
    column_req_t q;
    q.count  = c;
    q.tag    = t;
    q.bars   = b;
    q.hide   = h;
    q.page   = p;
    q.column = col;
    return q;
  endfunction

  // Random word: mostly on-panel spots, counts spread over every digit length,
  // around the ceiling and at the 32-bit top.
  function automatic column_req_t random_word();
    column_req_t q;
    int          k;
    logic [31:0] span;
    case ($urandom_range(0, 4))
      0: q.count = $urandom;
      1: begin
        k    = $urandom_range(1, 8);
        span = 1;
        repeat (k) span = span * 10;
        q.count = $urandom % span;
      end
      2: q.count = {5'd0, pixels.ceiling} + $urandom_range(0, 4) - 2;
      3: q.count = $urandom_range(0, 9);
      default: q.count = 32'hffffffff - $urandom_range(0, 3);
    endcase
    q.tag    = 3'($urandom_range(0, 7));
    q.bars   = 3'($urandom_range(0, 7));
    q.hide   = ($urandom_range(0, 6) == 0);
    q.page   = ($urandom_range(0, 99) < 88) ? 4'($urandom_range(0, 7))
                                             : 4'($urandom_range(8, 15));
    q.column = ($urandom_range(0, 99) < 85) ? 8'($urandom_range(0, 127))
                                             : 8'($urandom_range(128, 255));
    return q;
  endfunction

  initial begin
    column_req_t directed[$];
    logic [26:0] ceil;
    rst          <= 1'b1;
    cfg_write    <= 1'b0;
    cfg_data     <= '0;
    in_valid     <= 1'b0;
    count_value  <= '0;
    label_code   <= '0;
    battery_bars <= '0;
    blank_digits <= 1'b0;
    page_index   <= '0;
    column_index <= '0;
    repeat (7) @(negedge clk);
    rst <= 1'b0;

    // Directed words at the reset ceiling: lone zero digit, blanked leading
    // zeros, clamping, hidden digits, off-panel spots, every label, the label
    // none case and the battery edge cases including bars above four.
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd0, 1'b0, 4'd3,  8'd100));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd0, 1'b0, 4'd3,  8'd40));
    directed.push_back(mk(32'hffffffff, TAG_OPT,  3'd7, 1'b0, 4'd1,  8'd16));
    directed.push_back(mk(32'd99999999, TAG_ERR,  3'd4, 1'b0, 4'd6,  8'd27));
    directed.push_back(mk(32'd12345678, TAG_MAX,  3'd2, 1'b1, 4'd2,  8'd50));
    directed.push_back(mk(32'd87654321, TAG_RST,  3'd1, 1'b0, 4'd4,  8'd64));
    directed.push_back(mk(32'd5,        TAG_LO,   3'd3, 1'b0, 4'd5,  8'd109));
    directed.push_back(mk(32'hffffffff, TAG_OPT,  3'd7, 1'b1, 4'd15, 8'd255));
    directed.push_back(mk(32'd88888888, TAG_CHG,  3'd4, 1'b0, 4'd8,  8'd20));
    directed.push_back(mk(32'd1,        TAG_BAT,  3'd4, 1'b0, 4'd0,  8'd128));
    directed.push_back(mk(32'd0,        TAG_ERR,  3'd0, 1'b0, 4'd7,  8'd58));
    directed.push_back(mk(32'd0,        TAG_MAX,  3'd0, 1'b0, 4'd7,  8'd60));
    directed.push_back(mk(32'd0,        TAG_RST,  3'd0, 1'b0, 4'd7,  8'd62));
    directed.push_back(mk(32'd0,        TAG_LO,   3'd0, 1'b0, 4'd7,  8'd64));
    directed.push_back(mk(32'd0,        TAG_CHG,  3'd0, 1'b0, 4'd7,  8'd66));
    directed.push_back(mk(32'd0,        TAG_BAT,  3'd0, 1'b0, 4'd7,  8'd68));
    directed.push_back(mk(32'd0,        TAG_OPT,  3'd0, 1'b0, 4'd7,  8'd59));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd0, 1'b0, 4'd7,  8'd60));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd0, 1'b0, 4'd0,  8'd108));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd4, 1'b0, 4'd0,  8'd122));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd5, 1'b0, 4'd0,  8'd118));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd6, 1'b0, 4'd0,  8'd125));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd7, 1'b0, 4'd0,  8'd106));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd3, 1'b0, 4'd0,  8'd107));
    directed.push_back(mk(32'd0,        TAG_NONE, 3'd2, 1'b0, 4'd0,  8'd0));
    foreach (directed[i]) send_word(directed[i]);
    idle_sender();
    drain();

    // Random phases, each under its own ceiling: above eight digits, zero,
    // the eight-digit maximum, a small one, then random ones.
    for (int ph = 0; ph < 6; ph++) begin
      ceil = (ph < 4) ? CEIL_STEPS[ph] : 27'($urandom_range(0, 99999999));
      write_ceiling(ceil);
      if (ph == 2) begin
        // Hold the receiver off for a long stretch while words keep coming,
        // so the pipe fills and stalls its input.
        hold_asks++;
        steady_send = 1'b1;
        repeat (40) send_word(random_word());
      end
      for (int n = 0; n < PHASE_WORDS; n++) begin
        if (n % 50 == 0) steady_send = ($urandom_range(0, 3) == 0);
        send_word(random_word());
      end
      steady_send = 1'b0;
      // Pause the sender until every expected pixel word is back.
      idle_sender();
      drain();
    end

    repeat (20) @(posedge clk);
    if (pixels.errors == 0) begin
      $display("DONE: 0 errors");
    end else begin
      $display("DONE: errors detected");
    end
    $finish;
  end

endmodule

### filelist.f
hw/rtl/cdcr_pkg.sv
hw/rtl/cdcr_dabble.sv
hw/rtl/counter_display_column_renderer_top.sv
tb/counter_display_column_renderer_top_tb.sv
